>>> hw/rtl/nea_pkg.sv
// Package for the normal-equations accumulator: widths, item types and shared helpers.
// No dependencies.
`timescale 1ns / 1ps
package nea_pkg;
  localparam int unsigned Columns = 8;
  localparam int unsigned ColW = 3;
  localparam int unsigned TriDepth = Columns * (Columns + 1) / 2;
  localparam int unsigned TriW = 6;
  localparam int unsigned AccW = 56;
  localparam int unsigned ElemW = 16;
  localparam int unsigned ResW = 24;
  localparam int unsigned InDataW = 152;
  localparam int unsigned OutDataW = 64;

  localparam logic RegMode = 1'b0;
  localparam logic RegUcol = 1'b1;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [AccW-1:0] acc_t;

  typedef struct packed {
    logic               first;
    logic               last;
    logic               upd;
    logic [ColW-1:0]    ucol;
    logic signed [ResW-1:0] res;
    elem_t [Columns-1:0] elem;
  } row_t;

  typedef enum logic [1:0] {
    StAcc  = 2'd0,
    StTri  = 2'd1,
    StVec  = 2'd2
  } bk_state_e;

  function automatic logic [TriW-1:0] tri_idx(input logic [ColW-1:0] i, input logic [ColW-1:0] k);
    logic [ColW-1:0] a;
    logic [ColW-1:0] b;
    logic [TriW+3:0] base;
    a = (i < k) ? i : k;
    b = (i < k) ? k : i;
    base = TriW'(a) * TriW'(Columns) - ((TriW'(a) * (TriW'(a) - 1'b1)) >> 1);
    if (a == '0) base = '0;
    return TriW'(base + TriW'(b - a));
  endfunction

  function automatic acc_t sat_add(input acc_t x, input logic signed [AccW:0] y);
    logic signed [AccW+1:0] s;
    s = (AccW+2)'(x) + (AccW+2)'(y);
    if (s > (AccW+2)'(signed'({1'b0, {(AccW-1){1'b1}}}))) return {1'b0, {(AccW-1){1'b1}}};
    if (s < -(AccW+2)'(signed'({2'b01, {(AccW-1){1'b0}}}))) return {1'b1, {(AccW-1){1'b0}}};
    return s[AccW-1:0];
  endfunction
endpackage

>>> hw/rtl/nea_front.sv
// Front end: accepts rows, latches the register values with each row and queues them.
// Depends on nea_pkg.
`timescale 1ns / 1ps
module nea_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  output logic                      s_ready_o,
  input  logic [nea_pkg::InDataW-1:0] s_data_i,
  input  logic                      s_user_i,
  input  logic                      s_last_i,
  input  logic                      mode_i,
  input  logic [nea_pkg::ColW-1:0]  ucol_i,
  output logic                      q_valid_o,
  input  logic                      q_ready_i,
  output nea_pkg::row_t             q_row_o
);
  import nea_pkg::*;
  row_t buf_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  row_t in_row;
  logic push, pop;

  always_comb begin
    in_row.first = s_user_i;
    in_row.last = s_last_i;
    in_row.upd = mode_i;
    in_row.ucol = ({1'b0, ucol_i} >= (ColW+1)'(Columns)) ? ColW'(Columns - 1) : ucol_i;
    in_row.res = s_data_i[ResW-1:0];
    for (int j = 0; j < Columns; j++) in_row.elem[j] = s_data_i[ResW + ElemW*j +: ElemW];
  end

  assign s_ready_o = (cnt_q != 2'd2);
  assign push = s_valid_i && s_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_row_o = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> hw/rtl/nea_back.sv
// Back end: multiply-accumulate lanes over the triangle and vector, then result emission.
// Depends on nea_pkg.
`timescale 1ns / 1ps
module nea_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_ready_o,
  input  nea_pkg::row_t              q_row_i,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [nea_pkg::OutDataW-1:0] m_data_o,
  output logic                       m_last_o,
  output logic                       m_user_o
);
  import nea_pkg::*;
  acc_t tri_q [TriDepth];
  acc_t vec_q [Columns];
  logic [TriDepth-1:0] tval_q;
  logic [Columns-1:0] vval_q;
  bk_state_e st_q, st_d;
  logic upd_q, upd_d;
  logic [ColW-1:0] uc_q, uc_d, i_q, i_d, k_q, k_d;
  logic ov_q, ov_d;
  logic ovec_q, ovec_d, olast_q, olast_d;
  logic [ColW-1:0] or_q, or_d, oc_q, oc_d;
  acc_t oval_q, oval_d;
  logic take, slot;
  logic [TriDepth-1:0] hit;
  logic [TriW-1:0] ti;

  assign slot = !ov_q || m_ready_i;
  assign q_ready_o = (st_q == StAcc);
  assign take = q_valid_i && q_ready_o;

  always_comb begin
    hit = '0;
    for (int a = 0; a < Columns; a++)
      for (int b = 0; b < Columns; b++)
        if (a <= b && (!q_row_i.upd || a == q_row_i.ucol || b == q_row_i.ucol))
          hit[tri_idx(ColW'(a), ColW'(b))] = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int a = 0; a < Columns; a++) begin
        vec_q[a] <= sat_add((q_row_i.first || !vval_q[a]) ? '0 : vec_q[a],
                            -(AccW+1)'(q_row_i.elem[a] * q_row_i.res));
        for (int b = a; b < Columns; b++)
          if (hit[tri_idx(ColW'(a), ColW'(b))])
            tri_q[tri_idx(ColW'(a), ColW'(b))] <=
              sat_add((q_row_i.first || !tval_q[tri_idx(ColW'(a), ColW'(b))]) ? '0
                      : tri_q[tri_idx(ColW'(a), ColW'(b))],
                      (AccW+1)'(q_row_i.elem[a] * q_row_i.elem[b]));
      end
    end
  end

  always_comb begin
    st_d = st_q; upd_d = upd_q; uc_d = uc_q; i_d = i_q; k_d = k_q;
    ov_d = ov_q && !m_ready_i;
    ovec_d = ovec_q; olast_d = olast_q; or_d = or_q; oc_d = oc_q; oval_d = oval_q;
    ti = upd_q ? tri_idx(uc_q, k_q) : tri_idx(i_q, k_q);
    case (st_q)
      StAcc: begin
        if (take && q_row_i.last) begin
          st_d = StTri; upd_d = q_row_i.upd; uc_d = q_row_i.ucol;
          i_d = '0; k_d = '0;
        end
      end
      StTri: begin
        if (slot) begin
          ov_d = 1'b1; ovec_d = 1'b0; olast_d = 1'b0;
          or_d = upd_q ? uc_q : i_q; oc_d = k_q;
          oval_d = tval_q[ti] ? tri_q[ti] : '0;
          if (k_q == ColW'(Columns - 1)) begin
            if (upd_q || i_q == ColW'(Columns - 1)) begin
              st_d = StVec; i_d = '0;
            end else begin
              i_d = i_q + 1'b1; k_d = i_q + 1'b1;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      StVec: begin
        if (slot) begin
          ov_d = 1'b1; ovec_d = 1'b1; or_d = i_q; oc_d = '0;
          oval_d = vval_q[i_q] ? vec_q[i_q] : '0;
          olast_d = (i_q == ColW'(Columns - 1));
          if (olast_d) st_d = StAcc;
          i_d = i_q + 1'b1;
        end
      end
      default: st_d = StAcc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StAcc; ov_q <= 1'b0; tval_q <= '0; vval_q <= '0;
      upd_q <= 1'b0; uc_q <= '0; i_q <= '0; k_q <= '0;
    end else begin
      st_q <= st_d; ov_q <= ov_d; upd_q <= upd_d; uc_q <= uc_d; i_q <= i_d; k_q <= k_d;
      if (take) begin
        tval_q <= tval_q | hit;
        vval_q <= '1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ovec_q <= ovec_d; olast_q <= olast_d; or_q <= or_d; oc_q <= oc_d; oval_q <= oval_d;
  end

  assign m_valid_o = ov_q;
  assign m_data_o = {2'b00, oval_q, oc_q, or_q};
  assign m_last_o = olast_q;
  assign m_user_o = ovec_q;
endmodule

>>> hw/rtl/normal_equations_accumulator.sv
// Top level of the normal-equations accumulator: front queue, back end and config registers.
// Depends on nea_pkg, nea_front and nea_back.
`timescale 1ns / 1ps
// Usage: rows of a derivative matrix enter on the s_axis channel, one transaction per row.
// s_axis_tdata carries the residual and eight column values, s_axis_tuser the first row flag
// and s_axis_tlast the last row flag. The back end adds one row per cycle into the Gram
// triangle and the vector with parallel multiply-accumulate lanes, so rows are taken at one
// per cycle while accumulating.
// After a row flagged last, the back end emits one result transaction per cycle: 36 triangle
// entries and 8 vector entries in full mode, 8 matrix and 8 vector entries in update mode.
// During emission no row is accumulated; a two-entry queue in the front keeps taking rows
// until it fills. m_axis_tlast marks the final result of a run; m_axis_tuser is high for
// vector entries. When the receiver stalls, the output register holds and emission pauses.
// Reset clears the registers to zero and marks all accumulator entries empty, which read as
// zero. The user writes configuration through cfg_we_i, cfg_addr_i and cfg_data_i only while
// idle; the block itself does not enforce this.
module normal_equations_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [151:0] s_axis_tdata,  // residual, elem0 .. elem7
  input  logic        s_axis_tuser,   // first_row
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // row_index, col_index, acc_value, zero fill
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // is_vector
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [2:0]  cfg_data_i
);
  import nea_pkg::*;
  logic mode_q;
  logic [ColW-1:0] ucol_q;
  logic q_valid, q_ready;
  row_t q_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      ucol_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == RegMode) mode_q <= cfg_data_i[0];
      if (cfg_addr_i == RegUcol) ucol_q <= cfg_data_i;
    end
  end

  nea_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_user_i(s_axis_tuser), .s_last_i(s_axis_tlast),
    .mode_i(mode_q), .ucol_i(ucol_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_row_o(q_row)
  );

  nea_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_row_i(q_row),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_o(m_axis_tdata),
    .m_last_o(m_axis_tlast), .m_user_o(m_axis_tuser)
  );

  a_last_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser) else $error("last result not a vector entry");
  a_vec_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[5:3] == 3'd0) else $error("vector column");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !q_ready) else $error("row taken during emission");
endmodule

>>> verif/normal_equations_accumulator_tb.sv
// Testbench for normal_equations_accumulator: random and directed row streams with a scoreboard.
// Depends on nea_pkg and the normal_equations_accumulator RTL.
`timescale 1ns / 1ps
module normal_equations_accumulator_tb;
  import nea_pkg::*;

  typedef struct {
    logic        is_vec;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [55:0] val;
    logic        fin;
  } entry_t;

  class gram_scoreboard;
    logic        mode;
    logic [2:0]  ucol;
    longint      gram[TriDepth];
    longint      rhs[Columns];
    entry_t      pending[$];
    int          errors;
    int          matched;

    function int tri_pos(int i, int k);
      int a;
      int b;
      a = (i < k) ? i : k;
      b = (i < k) ? k : i;
      return a * Columns - (a * (a - 1)) / 2 + (b - a);
    endfunction

    function longint sat(longint v);
      longint hi;
      hi = (64'sd1 <<< 55) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void push(logic v, int r, int c, longint x);
      entry_t e;
      e.is_vec = v;
      e.row = r[2:0];
      e.col = c[2:0];
      e.val = x[55:0];
      e.fin = 1'b0;
      pending.push_back(e);
    endfunction

    function void note_row(logic first, logic last, logic signed [23:0] res,
                           logic signed [15:0] el[Columns]);
      int u;
      longint r;
      u = ucol;
      r = res;
      if (first) begin
        foreach (rhs[i]) rhs[i] = 0;
        if (!mode) begin
          foreach (gram[i]) gram[i] = 0;
        end else begin
          for (int k = 0; k < Columns; k++) gram[tri_pos(u, k)] = 0;
        end
      end
      for (int i = 0; i < Columns; i++) rhs[i] = sat(rhs[i] - longint'(el[i]) * r);
      if (!mode) begin
        for (int i = 0; i < Columns; i++)
          for (int k = i; k < Columns; k++)
            gram[tri_pos(i, k)] = sat(gram[tri_pos(i, k)] + longint'(el[i]) * longint'(el[k]));
      end else begin
        for (int k = 0; k < Columns; k++)
          gram[tri_pos(u, k)] = sat(gram[tri_pos(u, k)] + longint'(el[u]) * longint'(el[k]));
      end
      if (!last) return;
      if (!mode) begin
        for (int i = 0; i < Columns; i++)
          for (int k = i; k < Columns; k++) push(1'b0, i, k, gram[tri_pos(i, k)]);
      end else begin
        for (int k = 0; k < Columns; k++) push(1'b0, u, k, gram[tri_pos(u, k)]);
      end
      for (int i = 0; i < Columns; i++) push(1'b1, i, 0, rhs[i]);
      pending[$].fin = 1'b1;
    endfunction

    function void check_result(logic v, logic [2:0] r, logic [2:0] c, logic [55:0] x,
                               logic f);
      entry_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: is_vector=%0d row=%0d col=%0d", v, r, c);
        errors++;
        return;
      end
      e = pending.pop_front();
      matched++;
      if (v !== e.is_vec) begin
        $error("is_vector: expected %0d, got %0d", e.is_vec, v); errors++;
      end
      if (r !== e.row) begin
        $error("row_index: expected %0d, got %0d", e.row, r); errors++;
      end
      if (c !== e.col) begin
        $error("col_index: expected %0d, got %0d", e.col, c); errors++;
      end
      if (x !== e.val) begin
        $error("acc_value: expected %h, got %h", e.val, x); errors++;
      end
      if (f !== e.fin) begin
        $error("final_result: expected %0d, got %0d", e.fin, f); errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic         cfg_addr_i = 1'b0;
  logic [2:0]   cfg_data_i = '0;

  gram_scoreboard sb;
  int  rows_sent;
  int  idle_cycles;
  bit  hold_off;
  bit  done;
  int  runs;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  normal_equations_accumulator DUT (.*);

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      logic signed [15:0] el[Columns];
      for (int i = 0; i < Columns; i++) el[i] = s_axis_tdata[24 + 16 * i +: 16];
      sb.note_row(s_axis_tuser, s_axis_tlast, s_axis_tdata[23:0], el);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[61:6],
                      m_axis_tlast);
  end

  // The receiver stalls on its own pattern; a long hold-off can be requested.
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if ((sb != null) && (sb.matched % 50 < 20)) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !done) begin
      $display("normal_equations_accumulator verification failed");
      $finish;
    end
  end

  task automatic write_cfg(logic addr, logic [2:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == RegMode) sb.mode = data[0];
    else sb.ucol = data;
  endtask

  task automatic send_row(logic first, logic last, logic [23:0] res, logic [15:0] el[Columns]);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    s_axis_tdata[23:0] <= res;
    for (int i = 0; i < Columns; i++) s_axis_tdata[24 + 16 * i +: 16] <= el[i];
    do @(posedge clk_i); while (!s_axis_tready);
    rows_sent++;
  endtask

  task automatic gap();
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_elem(int kind);
    case (kind)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_frame(int nrows, bit extreme);
    logic [15:0] el[Columns];
    logic [23:0] res;
    for (int r = 0; r < nrows; r++) begin
      for (int i = 0; i < Columns; i++) el[i] = rand_elem(extreme ? $urandom_range(0, 1)
                                                                   : $urandom_range(0, 5));
      res = extreme ? ($urandom_range(0, 1) ? 24'h800000 : 24'h7fffff) : 24'($urandom);
      send_row(r == 0, r == nrows - 1, res, el);
      gap();
    end
  endtask

  initial begin
    logic [15:0] el[Columns];
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes in full mode and a frame with no last row.
    foreach (el[i]) el[i] = 16'h8000;
    send_row(1'b1, 1'b1, 24'h7fffff, el);
    foreach (el[i]) el[i] = 16'h7fff;
    send_row(1'b1, 1'b0, 24'h800000, el);
    send_row(1'b0, 1'b1, 24'h000000, el);
    send_row(1'b1, 1'b0, 24'h800000, el);
    foreach (el[i]) el[i] = 16'h0000;
    send_row(1'b1, 1'b1, 24'h000001, el);
    drain();
    random_frame(3, 1'b1);
    drain();
    write_cfg(RegMode, 3'd1);
    for (int u = 0; u < 8; u += 7) begin
      write_cfg(RegUcol, u[2:0]);
      random_frame(2, 1'b1);
      random_frame(3, 1'b0);
      drain();
    end

    // Long receiver hold-off while the sender keeps offering rows.
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (4) random_frame(6, 1'b0);
    join
    drain();

    while (rows_sent < 250) begin
      write_cfg(RegMode, 3'($urandom_range(0, 1)));
      write_cfg(RegUcol, 3'($urandom_range(0, 7)));
      runs++;
      for (int f = 0; f < 4; f++) random_frame($urandom_range(1, 6), $urandom_range(0, 9) == 0);
      drain();
    end
    done = 1'b1;

    $display("Sent %0d rows in full and update modes, %0d random configurations,", rows_sent,
             runs);
    $display("including full-scale extremes and a long output stall (%0d checked).", sb.matched);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("normal_equations_accumulator verification clean");
    else
      $display("normal_equations_accumulator verification failed");
    $finish;
  end
endmodule
